[rtl/lcdti_pkg.sv]
package lcdti_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_DOTS_PER_LINE   = 2'd0,
        CFG_HBLANK_DOT      = 2'd1,
        CFG_LINES_PER_FRAME = 2'd2,
        CFG_VBLANK_LINE     = 2'd3
    } cfg_idx_t;

    localparam int OFFSET_W   = 10;
    localparam int DOT_W      = 12;
    localparam int LINE_W     = 8;
    localparam int RAISE_W    = 14;
    localparam int IRQ_W      = 16;
    localparam int CFG_DATA_W = 12;

    localparam logic [OFFSET_W-1:0] OFF_STATUS   = 10'h004;
    localparam logic [OFFSET_W-1:0] OFF_MATCH    = 10'h005;
    localparam logic [OFFSET_W-1:0] OFF_LINE     = 10'h006;
    localparam logic [OFFSET_W-1:0] OFF_IE_LO    = 10'h200;
    localparam logic [OFFSET_W-1:0] OFF_IE_HI    = 10'h201;
    localparam logic [OFFSET_W-1:0] OFF_IF_LO    = 10'h202;
    localparam logic [OFFSET_W-1:0] OFF_IF_HI    = 10'h203;
    localparam logic [OFFSET_W-1:0] OFF_IME_LO   = 10'h208;
    localparam logic [OFFSET_W-1:0] OFF_IME_HI   = 10'h209;
    localparam logic [OFFSET_W-1:0] OFF_HALT     = 10'h301;

    localparam logic [DOT_W-1:0]  RST_DOTS_PER_LINE   = 12'd1232;
    localparam logic [DOT_W-1:0]  RST_HBLANK_DOT      = 12'd960;
    localparam logic [LINE_W-1:0] RST_LINES_PER_FRAME = 8'd228;
    localparam logic [LINE_W-1:0] RST_VBLANK_LINE     = 8'd160;

    localparam logic [7:0] STAT_WR_MASK   = 8'h38;
    localparam logic [7:0] STAT_KEEP_MASK = 8'h07;

    // status bit positions
    localparam int ST_VBLANK    = 0;
    localparam int ST_HBLANK    = 1;
    localparam int ST_MATCH     = 2;
    localparam int ST_VBLANK_IE = 3;
    localparam int ST_HBLANK_IE = 4;
    localparam int ST_MATCH_IE  = 5;

    // interrupt flag positions
    localparam int IRQ_VBLANK = 0;
    localparam int IRQ_HBLANK = 1;
    localparam int IRQ_MATCH  = 2;

    localparam int HALT_BIT = 7;

    typedef struct packed {
        op_t                 opcode;
        logic [OFFSET_W-1:0] reg_offset;
        logic [7:0]          write_data;
        logic [RAISE_W-1:0]  raise_irq_bits;
        logic                cpu_in_irq_mode;
        logic                cpu_irq_disabled;
    } item_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic              hblank_visible_event;
        logic [LINE_W-1:0] line_number;
        logic              vblank_event;
        logic              irq_take;
        logic              wake;
        logic              halt_request;
    } result_t;

    typedef struct packed {
        logic                  valid;
        cfg_idx_t              index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

[rtl/lcdti_core.sv]
module lcdti_core
    import lcdti_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_wr_t cfg,
    input  logic    item_fire,
    input  item_t   item,
    output result_t res
);

    logic [DOT_W-1:0]  dots_per_line_reg;
    logic [DOT_W-1:0]  hblank_dot_reg;
    logic [LINE_W-1:0] lines_per_frame_reg;
    logic [LINE_W-1:0] vblank_line_reg;

    logic [DOT_W-1:0]  dot_count_reg,  dot_count_next;
    logic [LINE_W-1:0] line_count_reg, line_count_next;
    logic [7:0]        status_reg,     status_next;
    logic [LINE_W-1:0] match_reg,      match_next;
    logic [IRQ_W-1:0]  ie_reg,         ie_next;
    logic [IRQ_W-1:0]  if_reg,         if_next;
    logic [IRQ_W-1:0]  ime_reg,        ime_next;

    logic [DOT_W-1:0]  dot_inc;
    logic [LINE_W:0]   line_inc;
    logic [LINE_W-1:0] line_wrap;
    logic              pending;
    logic [7:0]        rd_byte;

    assign dot_inc   = dot_count_reg + {{(DOT_W-1){1'b0}}, 1'b1};
    assign line_inc  = {1'b0, line_count_reg} + {{LINE_W{1'b0}}, 1'b1};
    assign line_wrap = (line_inc >= {1'b0, lines_per_frame_reg}) ? '0 : line_inc[LINE_W-1:0];
    assign pending   = |(ie_reg & if_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dots_per_line_reg   <= RST_DOTS_PER_LINE;
            hblank_dot_reg      <= RST_HBLANK_DOT;
            lines_per_frame_reg <= RST_LINES_PER_FRAME;
            vblank_line_reg     <= RST_VBLANK_LINE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DOTS_PER_LINE:   dots_per_line_reg   <= cfg.data;
                CFG_HBLANK_DOT:      hblank_dot_reg      <= cfg.data;
                CFG_LINES_PER_FRAME: lines_per_frame_reg <= cfg.data[LINE_W-1:0];
                CFG_VBLANK_LINE:     vblank_line_reg     <= cfg.data[LINE_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (item.reg_offset)
            OFF_STATUS: rd_byte = status_reg;
            OFF_MATCH:  rd_byte = match_reg;
            OFF_LINE:   rd_byte = line_count_reg;
            OFF_IE_LO:  rd_byte = ie_reg[7:0];
            OFF_IE_HI:  rd_byte = ie_reg[15:8];
            OFF_IF_LO:  rd_byte = if_reg[7:0];
            OFF_IF_HI:  rd_byte = if_reg[15:8];
            OFF_IME_LO: rd_byte = ime_reg[7:0];
            OFF_IME_HI: rd_byte = ime_reg[15:8];
            default:    rd_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        dot_count_next  = dot_count_reg;
        line_count_next = line_count_reg;
        status_next     = status_reg;
        match_next      = match_reg;
        ie_next         = ie_reg;
        if_next         = if_reg;
        ime_next        = ime_reg;
        res             = '0;

        unique case (item.opcode)
            OP_TICK:
            begin
                if_next        = if_reg | {{(IRQ_W-RAISE_W){1'b0}}, item.raise_irq_bits};
                dot_count_next = dot_inc;
                if (dot_inc == hblank_dot_reg)
                begin
                    status_next[ST_HBLANK] = 1'b1;
                    if (status_next[ST_HBLANK_IE])
                    begin
                        if_next[IRQ_HBLANK] = 1'b1;
                    end
                    res.hblank_visible_event = (line_count_reg < vblank_line_reg);
                end
                // end of line
                if (dot_inc >= dots_per_line_reg)
                begin
                    dot_count_next         = '0;
                    status_next[ST_HBLANK] = 1'b0;
                    line_count_next        = line_wrap;
                    if (line_wrap == match_reg)
                    begin
                        status_next[ST_MATCH] = 1'b1;
                        if (status_next[ST_MATCH_IE])
                        begin
                            if_next[IRQ_MATCH] = 1'b1;
                        end
                    end
                    else
                    begin
                        status_next[ST_MATCH] = 1'b0;
                    end
                    if (line_wrap == vblank_line_reg)
                    begin
                        status_next[ST_VBLANK] = 1'b1;
                        if (status_next[ST_VBLANK_IE])
                        begin
                            if_next[IRQ_VBLANK] = 1'b1;
                        end
                        res.vblank_event = 1'b1;
                    end
                    else if (line_wrap == '0)
                    begin
                        status_next[ST_VBLANK] = 1'b0;
                    end
                end
            end
            OP_WRITE:
            begin
                unique case (item.reg_offset)
                    OFF_STATUS: status_next = (status_reg & STAT_KEEP_MASK)
                                            | (item.write_data & STAT_WR_MASK);
                    OFF_MATCH:  match_next = item.write_data;
                    OFF_IE_LO:  ie_next[7:0] = item.write_data;
                    OFF_IE_HI:  ie_next[15:8] = item.write_data;
                    OFF_IF_LO:  if_next[7:0] = if_reg[7:0] & ~item.write_data;
                    OFF_IF_HI:  if_next[15:8] = if_reg[15:8] & ~item.write_data;
                    OFF_IME_LO: ime_next[7:0] = item.write_data;
                    OFF_IME_HI: ime_next[15:8] = item.write_data;
                    OFF_HALT:   res.halt_request = ~item.write_data[HALT_BIT];
                    default:    ;
                endcase
            end
            OP_READ:
            begin
                res.read_data = rd_byte;
            end
            OP_CHECK:
            begin
                res.wake     = pending;
                res.irq_take = pending && ime_reg[0] && !item.cpu_in_irq_mode
                               && !item.cpu_irq_disabled;
            end
            default: ;
        endcase

        res.line_number = line_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_count_reg  <= '0;
            line_count_reg <= '0;
            status_reg     <= '0;
            match_reg      <= '0;
            ie_reg         <= '0;
            if_reg         <= '0;
            ime_reg        <= '0;
        end
        else if (item_fire)
        begin
            dot_count_reg  <= dot_count_next;
            line_count_reg <= line_count_next;
            status_reg     <= status_next;
            match_reg      <= match_next;
            ie_reg         <= ie_next;
            if_reg         <= if_next;
            ime_reg        <= ime_next;
        end
    end

`ifndef SYNTH
    a_line_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> line_count_reg == $past(res.line_number))
        else $error("line counter differs from reported line");

    a_check_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.opcode == OP_CHECK |=>
            $stable(if_reg) && $stable(status_reg) && $stable(dot_count_reg))
        else $error("check item changed state");

    a_take_needs_wake: assert property (@(posedge clk) disable iff (!rst_n)
        res.irq_take |-> res.wake && ime_reg[0])
        else $error("irq taken without pending enabled interrupt");

    a_dot_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.opcode != OP_TICK |=> $stable(dot_count_reg)
            && $stable(line_count_reg))
        else $error("timing advanced on a non-tick item");
`endif

endmodule

[rtl/lcd_timing_and_interrupt_flags_unit.sv]
// Scanline timing generator with status byte and interrupt flags. One item
// is accepted every clock cycle while the output is not stalled; its result
// leaves through the input register, then the result register, and the next
// item may enter while a result waits on m_axis_tready. The sustained rate of
// one item per cycle is set by the single update of the timing and interrupt
// registers between the two registers. Configuration writes are taken on every
// cycle and must only be issued while no item is in flight.
module lcd_timing_and_interrupt_flags_unit
    import lcdti_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // reg_offset, write_data, raise_irq_bits, cpu_in_irq_mode, cpu_irq_disabled
    input  logic [39:0]           s_axis_tdata,
    // opcode
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data, hblank_visible_event, line_number, vblank_event, irq_take,
    // wake, halt_request
    output logic [23:0]           m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    item_t   s_item;
    cfg_wr_t cfg;
    logic    advance;
    logic    s_fire;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_idx_t'(cfg_index);
    assign cfg.data  = cfg_data;

    assign s_item.opcode           = op_t'(s_axis_tuser);
    assign s_item.reg_offset       = s_axis_tdata[9:0];
    assign s_item.write_data       = s_axis_tdata[17:10];
    assign s_item.raise_irq_bits   = s_axis_tdata[31:18];
    assign s_item.cpu_in_irq_mode  = s_axis_tdata[32];
    assign s_item.cpu_irq_disabled = s_axis_tdata[33];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    lcdti_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_fire (advance),
        .item      (in_item_reg),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_res_reg.halt_request,
                            out_res_reg.wake,
                            out_res_reg.irq_take,
                            out_res_reg.vblank_event,
                            out_res_reg.line_number,
                            out_res_reg.hblank_visible_event,
                            out_res_reg.read_data};

endmodule
